>>> rtl/core/sbs_pkg.sv
`timescale 1ns / 1ps

package sbs_pkg;

	// Frame limits and field widths.
	localparam int MAX_READINGS = 256;
	localparam int READING_W    = 16;
	localparam int VALUE_W      = 15;
	localparam int CNT_W        = 9;
	localparam int SUM_W        = 24;
	localparam int INDEX_W      = 8;
	localparam int CFG_IDX_W    = 2;

	// Register reset values, 1/16 degree units.
	localparam logic signed [READING_W-1:0] NORMAL_MAX_RST   = 16'sd464;
	localparam logic signed [READING_W-1:0] WARNING_MAX_RST  = 16'sd704;
	localparam logic signed [READING_W-1:0] CRITICAL_MAX_RST = 16'sd944;
	localparam logic signed [READING_W-1:0] ALERT_MIN_RST    = 16'sd720;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_MAX   = 2'd0,
		REG_WARNING_MAX  = 2'd1,
		REG_CRITICAL_MAX = 2'd2,
		REG_ALERT_MIN    = 2'd3
	} sbs_reg_t;

	// Statistics of one frame, handed from the front to the back.
	typedef struct packed {
		logic [CNT_W-1:0]   errors;
		logic [CNT_W-1:0]   normal;
		logic [CNT_W-1:0]   warning;
		logic [CNT_W-1:0]   critical;
		logic [CNT_W-1:0]   shutdown;
		logic [CNT_W-1:0]   valid_cnt;
		logic [VALUE_W-1:0] low_mark;
		logic [VALUE_W-1:0] high_mark;
		logic [SUM_W-1:0]   sum;
		logic               alert_found;
		logic [INDEX_W-1:0] alert_index;
		logic [VALUE_W-1:0] alert_value;
	} sbs_frame_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} sbs_q_stat_t;

endpackage

>>> rtl/core/sbs_in_if.sv
`timescale 1ns / 1ps

interface sbs_in_if import sbs_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [READING_W-1:0] reading;
	logic                        last;

	modport source (output valid, output reading, output last, input ready);
	modport sink (input valid, input reading, input last, output ready);
endinterface

>>> rtl/core/sbs_out_if.sv
`timescale 1ns / 1ps

interface sbs_out_if import sbs_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   error_count;
	logic [CNT_W-1:0]   normal_count;
	logic [CNT_W-1:0]   warning_count;
	logic [CNT_W-1:0]   critical_count;
	logic [CNT_W-1:0]   shutdown_count;
	logic [VALUE_W-1:0] min_reading;
	logic [VALUE_W-1:0] max_reading;
	logic [VALUE_W-1:0] average_reading;
	logic               alert_found;
	logic [INDEX_W-1:0] alert_index;
	logic [VALUE_W-1:0] alert_reading;
	logic               no_valid;

	modport source (
		output valid, input ready,
		output error_count, output normal_count, output warning_count,
		output critical_count, output shutdown_count, output min_reading,
		output max_reading, output average_reading, output alert_found,
		output alert_index, output alert_reading, output no_valid
	);
	modport sink (
		input valid, output ready,
		input error_count, input normal_count, input warning_count,
		input critical_count, input shutdown_count, input min_reading,
		input max_reading, input average_reading, input alert_found,
		input alert_index, input alert_reading, input no_valid
	);
endinterface

>>> rtl/core/sensor_reading_band_stats_unit.sv
// Throughput: one reading per cycle while the frame queue has room.
// The summary leaves the back after the frame marked last has passed the
// two-entry queue and the bit-serial divider; the back takes longer over one
// frame than a short frame takes to arrive, so the queue absorbs short frames.
// Reset clears frame state, queue and sequencer at once and loads the band
// and alert registers with their defaults.
`timescale 1ns / 1ps

module sensor_reading_band_stats_unit import sbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [READING_W-1:0] cfg_data,
	sbs_in_if.sink               samples,
	sbs_out_if.source            summary
);

	sbs_q_stat_t q_stat;
	logic        push;
	logic        pop;
	sbs_frame_t  push_frame;
	sbs_frame_t  head;

	// Front: classification and per-frame accumulation.
	sbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.samples    (samples),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	// Queue of finished frames.
	sbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back: average division and summary output.
	sbs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.summary (summary)
	);

endmodule

>>> rtl/core/sbs_front.sv
`timescale 1ns / 1ps

module sbs_front import sbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [READING_W-1:0]  cfg_data,
	sbs_in_if.sink                samples,
	input  sbs_q_stat_t           q_stat,
	output logic                  push,
	output sbs_frame_t            push_frame
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READINGS);

	logic signed [READING_W-1:0] normal_max_q;
	logic signed [READING_W-1:0] warning_max_q;
	logic signed [READING_W-1:0] critical_max_q;
	logic signed [READING_W-1:0] alert_min_q;

	sbs_frame_t       cur_q;
	sbs_frame_t       nxt;
	logic [CNT_W-1:0] position_q;
	logic             accept;
	logic             in_frame;
	logic [VALUE_W-1:0] value;
	logic [SUM_W:0]   sum_wide;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c < MAX_CNT) ? c + 1'b1 : c;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_max_q   <= NORMAL_MAX_RST;
			warning_max_q  <= WARNING_MAX_RST;
			critical_max_q <= CRITICAL_MAX_RST;
			alert_min_q    <= ALERT_MIN_RST;
		end else if (cfg_we) begin
			case (sbs_reg_t'(cfg_index))
				REG_NORMAL_MAX:   normal_max_q   <= cfg_data;
				REG_WARNING_MAX:  warning_max_q  <= cfg_data;
				REG_CRITICAL_MAX: critical_max_q <= cfg_data;
				REG_ALERT_MIN:    alert_min_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A beat is taken whenever the queue can hold a finished frame.
	assign samples.ready = !q_stat.full;
	assign accept        = samples.valid && samples.ready;
	assign in_frame      = position_q < MAX_CNT;
	assign value         = samples.reading[VALUE_W-1:0];
	assign sum_wide      = {1'b0, cur_q.sum} + (SUM_W+1)'(value);

	// Classify the reading and fold it into the frame statistics.
	always_comb begin
		nxt = cur_q;
		if (in_frame) begin
			if (samples.reading < 0) begin
				nxt.errors = bump(cur_q.errors);
			end else begin
				if (cur_q.valid_cnt == '0) begin
					nxt.low_mark  = value;
					nxt.high_mark = value;
				end else begin
					if (value < cur_q.low_mark)  nxt.low_mark  = value;
					if (value > cur_q.high_mark) nxt.high_mark = value;
				end
				nxt.sum       = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
				nxt.valid_cnt = bump(cur_q.valid_cnt);
				if (samples.reading <= normal_max_q) begin
					nxt.normal = bump(cur_q.normal);
				end else if (samples.reading <= warning_max_q) begin
					nxt.warning = bump(cur_q.warning);
				end else if (samples.reading <= critical_max_q) begin
					nxt.critical = bump(cur_q.critical);
				end else begin
					nxt.shutdown = bump(cur_q.shutdown);
				end
				if (!cur_q.alert_found && samples.reading >= alert_min_q) begin
					nxt.alert_found = 1'b1;
					nxt.alert_index = position_q[INDEX_W-1:0];
					nxt.alert_value = value;
				end
			end
		end
	end

	assign push       = accept && samples.last;
	assign push_frame = nxt;

	// Frame state; cleared after the last beat of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			position_q <= '0;
		end else if (accept) begin
			if (samples.last) begin
				cur_q      <= '0;
				position_q <= '0;
			end else begin
				cur_q <= nxt;
				if (in_frame) position_q <= position_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/sbs_queue.sv
`timescale 1ns / 1ps

module sbs_queue import sbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sbs_frame_t  push_frame,
	input  logic        pop,
	output sbs_frame_t  head,
	output sbs_q_stat_t q_stat
);

	sbs_frame_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q == 2'd2;
	assign q_stat.empty = count_q == 2'd0;

	// Frame storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_frame;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/sbs_back.sv
`timescale 1ns / 1ps

module sbs_back import sbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sbs_frame_t  head,
	input  sbs_q_stat_t q_stat,
	output logic        pop,
	sbs_out_if.source   summary
);

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
	localparam logic [SUM_W-1:0]  AVG_LIMIT = SUM_W'((1 << VALUE_W) - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	sbs_frame_t         rec_q;
	logic [CNT_W-1:0]   rem_q;
	logic [SUM_W-1:0]   quo_q;
	logic [VALUE_W-1:0] avg_q;
	logic [CNT_W:0]     trial;
	logic               take;
	logic [CNT_W:0]     diff;
	logic [SUM_W-1:0]   quo_nxt;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// One restoring division step: sum over valid count, one bit a cycle.
	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign take    = trial >= {1'b0, rec_q.valid_cnt};
	assign diff    = trial - {1'b0, rec_q.valid_cnt};
	assign quo_nxt = {quo_q[SUM_W-2:0], take};

	// Sequencer: load a frame, divide, hold the summary until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			summary.valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q       <= ST_OUT;
						summary.valid <= 1'b1;
					end
				end
				ST_OUT: begin
					if (summary.ready) begin
						state_q       <= ST_IDLE;
						summary.valid <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the divider and the frame record.
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
			rem_q <= '0;
			quo_q <= head.sum;
		end else if (state_q == ST_DIV) begin
			rem_q <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= quo_nxt;
			if (step_q == LAST_STEP) begin
				if (rec_q.valid_cnt == '0) begin
					avg_q <= '0;
				end else if (quo_nxt > AVG_LIMIT) begin
					avg_q <= AVG_LIMIT[VALUE_W-1:0];
				end else begin
					avg_q <= quo_nxt[VALUE_W-1:0];
				end
			end
		end
	end

	// Summary payload.
	assign summary.error_count     = rec_q.errors;
	assign summary.normal_count    = rec_q.normal;
	assign summary.warning_count   = rec_q.warning;
	assign summary.critical_count  = rec_q.critical;
	assign summary.shutdown_count  = rec_q.shutdown;
	assign summary.min_reading     = rec_q.low_mark;
	assign summary.max_reading     = rec_q.high_mark;
	assign summary.average_reading = avg_q;
	assign summary.alert_found     = rec_q.alert_found;
	assign summary.alert_index     = rec_q.alert_index;
	assign summary.alert_reading   = rec_q.alert_value;
	assign summary.no_valid        = rec_q.valid_cnt == '0;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sbs_pkg::*;

	// One frame summary as it leaves the block.
	typedef struct packed {
		logic [CNT_W-1:0]   errors;
		logic [CNT_W-1:0]   normal;
		logic [CNT_W-1:0]   warning;
		logic [CNT_W-1:0]   critical;
		logic [CNT_W-1:0]   shutdown;
		logic [VALUE_W-1:0] min_reading;
		logic [VALUE_W-1:0] max_reading;
		logic [VALUE_W-1:0] average_reading;
		logic               alert_found;
		logic [INDEX_W-1:0] alert_index;
		logic [VALUE_W-1:0] alert_reading;
		logic               no_valid;
	} band_summary_t;

	// Kinds of reading content for generated frames.
	typedef enum int {
		READ_MIXED,
		READ_LOW,
		READ_NEGATIVE
	} read_kind_t;

	// Keeps its own copy of the band registers and frame state, works out the
	// summary of each frame and checks it against what the block delivers.
	class band_stats_board;
		logic signed [READING_W-1:0] normal_max;
		logic signed [READING_W-1:0] warning_max;
		logic signed [READING_W-1:0] critical_max;
		logic signed [READING_W-1:0] alert_min;

		int unsigned errors_seen;
		int unsigned normal_seen;
		int unsigned warning_seen;
		int unsigned critical_seen;
		int unsigned shutdown_seen;
		int unsigned valid_seen;
		int unsigned item_position;
		int unsigned running_sum;
		logic signed [READING_W-1:0] low_mark;
		logic signed [READING_W-1:0] high_mark;
		logic signed [READING_W-1:0] alert_value;
		bit          alert_seen;
		int unsigned alert_position;

		band_summary_t pending_summaries[$];
		int unsigned   mismatches;
		int unsigned   frames_checked;
		int unsigned   readings_noted;

		function new();
			set_bands(NORMAL_MAX_RST, WARNING_MAX_RST, CRITICAL_MAX_RST, ALERT_MIN_RST);
			clear_frame();
			mismatches = 0;
			frames_checked = 0;
			readings_noted = 0;
		endfunction

		function void set_bands(logic signed [READING_W-1:0] nm, logic signed [READING_W-1:0] wm,
				logic signed [READING_W-1:0] cm, logic signed [READING_W-1:0] am);
			normal_max = nm;
			warning_max = wm;
			critical_max = cm;
			alert_min = am;
		endfunction

		function void clear_frame();
			errors_seen = 0;
			normal_seen = 0;
			warning_seen = 0;
			critical_seen = 0;
			shutdown_seen = 0;
			valid_seen = 0;
			item_position = 0;
			running_sum = 0;
			low_mark = '0;
			high_mark = '0;
			alert_value = '0;
			alert_seen = 0;
			alert_position = 0;
		endfunction

		function int unsigned sat_inc(int unsigned c);
			return (c < MAX_READINGS) ? c + 1 : c;
		endfunction

		// Accepted reading: update the frame and, on the last beat, queue its summary.
		function void note_reading(logic signed [READING_W-1:0] r, logic last);
			band_summary_t s;
			int unsigned   rv;
			int unsigned   avg;
			readings_noted++;
			if (item_position < MAX_READINGS) begin
				if (r < 0) begin
					errors_seen = sat_inc(errors_seen);
				end else begin
					if (valid_seen == 0) begin
						low_mark = r;
						high_mark = r;
					end
					if (r < low_mark) low_mark = r;
					if (r > high_mark) high_mark = r;
					rv = int'(r);
					running_sum = running_sum + rv;
					if (running_sum > 32'hFF_FFFF) running_sum = 32'hFF_FFFF;
					valid_seen = sat_inc(valid_seen);
					if (r <= normal_max) normal_seen = sat_inc(normal_seen);
					else if (r <= warning_max) warning_seen = sat_inc(warning_seen);
					else if (r <= critical_max) critical_seen = sat_inc(critical_seen);
					else shutdown_seen = sat_inc(shutdown_seen);
					// Only valid readings can become the alert.
					if (!alert_seen && r >= alert_min) begin
						alert_seen = 1;
						alert_position = item_position;
						alert_value = r;
					end
				end
				item_position++;
			end
			if (!last) return;

			s = '0;
			s.errors = errors_seen[CNT_W-1:0];
			s.normal = normal_seen[CNT_W-1:0];
			s.warning = warning_seen[CNT_W-1:0];
			s.critical = critical_seen[CNT_W-1:0];
			s.shutdown = shutdown_seen[CNT_W-1:0];
			if (valid_seen != 0) begin
				avg = running_sum / valid_seen;
				if (avg > 32767) avg = 32767;
				s.min_reading = low_mark[VALUE_W-1:0];
				s.max_reading = high_mark[VALUE_W-1:0];
				s.average_reading = avg[VALUE_W-1:0];
			end
			s.alert_found = alert_seen;
			if (alert_seen) begin
				s.alert_index = alert_position[INDEX_W-1:0];
				s.alert_reading = alert_value[VALUE_W-1:0];
			end
			s.no_valid = (valid_seen == 0);
			pending_summaries.push_back(s);
			clear_frame();
		endfunction

		function void compare_field(string what, logic [31:0] exp, logic [31:0] act);
			if (exp !== act) begin
				mismatches++;
				$display("%0t: frame %0d %s expected %0d actual %0d",
					$time, frames_checked, what, exp, act);
			end
		endfunction

		// Accepted summary beat: compare with the oldest frame still owed.
		function void check_summary(band_summary_t got);
			band_summary_t exp;
			if (pending_summaries.size() == 0) begin
				mismatches++;
				$display("%0t: summary with no frame owed, expected none actual errors=%0d",
					$time, got.errors);
				return;
			end
			exp = pending_summaries.pop_front();
			compare_field("error_count", exp.errors, got.errors);
			compare_field("normal_count", exp.normal, got.normal);
			compare_field("warning_count", exp.warning, got.warning);
			compare_field("critical_count", exp.critical, got.critical);
			compare_field("shutdown_count", exp.shutdown, got.shutdown);
			compare_field("min_reading", exp.min_reading, got.min_reading);
			compare_field("max_reading", exp.max_reading, got.max_reading);
			compare_field("average_reading", exp.average_reading, got.average_reading);
			compare_field("alert_found", exp.alert_found, got.alert_found);
			compare_field("alert_index", exp.alert_index, got.alert_index);
			compare_field("alert_reading", exp.alert_reading, got.alert_reading);
			compare_field("no_valid", exp.no_valid, got.no_valid);
			frames_checked++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [READING_W-1:0] cfg_data;
	bit                   no_gaps = 0;
	int unsigned          settings_used = 1;
	band_stats_board      board;

	sbs_in_if  samples ();
	sbs_out_if summary ();

	sensor_reading_band_stats_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples),
		.summary   (summary)
	);

	always #4 clk = ~clk;

	// Hard limit on the run, far above the slowest correct run.
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic signed [READING_W-1:0] pick_reading(read_kind_t kind);
		int unsigned sel;
		int          base;
		case (kind)
			READ_LOW:      return 16'($urandom_range(0, 400));
			READ_NEGATIVE: return {1'b1, 15'($urandom)};
			default: begin
				sel = $urandom_range(0, 99);
				if (sel < 18) return {1'b1, 15'($urandom)};
				if (sel < 32) return {1'b0, 15'($urandom)};
				// Most readings sit close to a band edge or the alert level.
				case ($urandom_range(0, 4))
					0:       base = board.normal_max;
					1:       base = board.warning_max;
					2:       base = board.critical_max;
					3:       base = board.alert_min;
					default: base = 0;
				endcase
				return 16'(base + int'($urandom_range(0, 6)) - 3);
			end
		endcase
	endfunction

	// Offer one reading beat and hold it until the block takes it.
	task automatic send_beat(input logic signed [READING_W-1:0] r, input logic last);
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < 19) begin
				samples.valid <= 1'b0;
				@(posedge clk);
			end
		end
		samples.valid <= 1'b1;
		samples.reading <= r;
		samples.last <= last;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		board.note_reading(r, last);
	endtask

	task automatic send_frame(input int unsigned len, input read_kind_t kind);
		for (int unsigned i = 0; i < len; i++) begin
			send_beat(pick_reading(kind), i == len - 1);
		end
	endtask

	task automatic send_random_frames(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		int unsigned sel;
		sent = 0;
		while (sent < budget) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) len = $urandom_range(1, 8);
			else if (sel < 95) len = $urandom_range(9, 40);
			else len = $urandom_range(41, 120);
			send_frame(len, READ_MIXED);
			sent += len;
		end
	endtask

	// The sender stops until every summary owed has come and the back is quiet.
	task automatic wait_idle();
		samples.valid <= 1'b0;
		while (board.pending_summaries.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Write all four band registers on consecutive cycles while the block is idle.
	task automatic configure(input logic signed [READING_W-1:0] nm,
			input logic signed [READING_W-1:0] wm, input logic signed [READING_W-1:0] cm,
			input logic signed [READING_W-1:0] am);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_NORMAL_MAX;
		cfg_data <= nm;
		@(posedge clk);
		cfg_index <= REG_WARNING_MAX;
		cfg_data <= wm;
		@(posedge clk);
		cfg_index <= REG_CRITICAL_MAX;
		cfg_data <= cm;
		@(posedge clk);
		cfg_index <= REG_ALERT_MIN;
		cfg_data <= am;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_bands(nm, wm, cm, am);
		settings_used++;
	endtask

	// Summary side: random back-pressure, one long hold-off, and checking.
	// The hold-off starts right after the first summary, while the directed
	// frames are still being offered, so the queue fills and the input stalls.
	initial begin : receive_summaries
		band_summary_t got;
		int unsigned   hold_left;
		bit            hold_done;
		hold_left = 0;
		hold_done = 0;
		summary.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (summary.valid && summary.ready) begin
				got.errors = summary.error_count;
				got.normal = summary.normal_count;
				got.warning = summary.warning_count;
				got.critical = summary.critical_count;
				got.shutdown = summary.shutdown_count;
				got.min_reading = summary.min_reading;
				got.max_reading = summary.max_reading;
				got.average_reading = summary.average_reading;
				got.alert_found = summary.alert_found;
				got.alert_index = summary.alert_index;
				got.alert_reading = summary.alert_reading;
				got.no_valid = summary.no_valid;
				board.check_summary(got);
			end
			if (!hold_done && board.frames_checked >= 1) begin
				hold_done = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				summary.ready <= 1'b0;
			end else if (no_gaps) begin
				summary.ready <= 1'b1;
			end else begin
				summary.ready <= ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// Stimulus: directed frames at the reset bands, then random phases.
	initial begin : drive_readings
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_NORMAL_MAX;
		cfg_data <= '0;
		samples.valid <= 1'b0;
		samples.reading <= '0;
		samples.last <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A frame of errors only, down to the most negative value.
		send_beat(-16'sd32768, 1'b0);
		send_beat(-16'sd1, 1'b1);
		// A single zero reading.
		send_beat(16'sd0, 1'b1);
		// Every band edge, an error ahead of the alert, and the largest reading.
		send_beat(-16'sd5, 1'b0);
		send_beat(16'sd719, 1'b0);
		send_beat(16'sd464, 1'b0);
		send_beat(16'sd465, 1'b0);
		send_beat(16'sd704, 1'b0);
		send_beat(16'sd705, 1'b0);
		send_beat(16'sd944, 1'b0);
		send_beat(16'sd945, 1'b0);
		send_beat(16'sd720, 1'b0);
		send_beat(16'sd32767, 1'b1);
		// Truncated average and no alert.
		send_beat(16'sd100, 1'b0);
		send_beat(16'sd200, 1'b0);
		send_beat(16'sd301, 1'b1);
		// Alternating bit patterns.
		send_beat(16'sh5555, 1'b0);
		send_beat(16'sh2AAA, 1'b1);

		// Over-long frames: counters saturate and late items are dropped.
		send_frame(258, READ_LOW);
		send_frame(257, READ_NEGATIVE);

		// Ordered random bands with both sides running flat out.
		configure(16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 2800)),
			16'($urandom_range(2800, 3600)), 16'($urandom_range(0, 3000)));
		no_gaps = 1;
		send_random_frames(100);
		no_gaps = 0;

		// Lowest settings: every valid reading is shutdown, and the first valid reading of each frame raises the alert.
		configure(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_beat(-16'sd3, 1'b0);
		send_beat(-16'sd32768, 1'b0);
		send_beat(16'sd5, 1'b1);
		send_random_frames(70);

		// Highest settings: every valid reading is normal, alert only at full scale.
		configure(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_random_frames(70);

		// Unordered random bands.
		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		send_random_frames(90);

		wait_idle();
		$display("Covered %0d readings in %0d frames over %0d band settings.",
			board.readings_noted, board.frames_checked, settings_used);
		$display("Field mismatches found: %0d.", board.mismatches);
		if (board.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
